// ===== src/ndis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ndis_pkg;

  localparam int ValueWidth = 32;
  localparam int IndexWidth = 6;

  typedef struct packed {
    logic                         valid;
    logic signed [ValueWidth-1:0] value;
    logic [IndexWidth-1:0]        pos;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

// ===== src/ndis_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ndis_cell
  import ndis_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     new_entry,
  input  wire entry_t     prev_entry,
  input  wire logic       prev_keep,
  input  wire entry_t     next_entry,
  output entry_t          entry,
  output logic            keep
);

  entry_t entry_next;

  // stays put when it ranks at or above the incoming value (ties keep arrival order)
  assign keep = entry.valid && (entry.value >= new_entry.value);

  always_comb begin
    entry_next = entry;
    if (ctrl.drain) begin
      entry_next = next_entry;
    end else if (ctrl.insert && !keep) begin
      if (prev_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = prev_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.value <= entry_next.value;
    entry.pos   <= entry_next.pos;
  end

endmodule
`default_nettype wire

// ===== src/nonzero_descending_index_sort_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sorts the nonzero elements of a vector, largest first, with their positions.
// Input channel (in_valid/in_ready): one element per transaction, value and
// last; last marks the final element. Zero elements are dropped. One element
// is taken per cycle while the list is filling; each goes into a chain of
// MAX_ITEMS cells in the cycle it is accepted.
// Output channel (out_valid/out_ready): after the final element the state
// register enters the drain and the chain shifts out towards cell 0 via the
// output register, one result per cycle while the receiver takes them;
// end_of_list marks the last result. An all-zero vector gives a single
// result of value 0, index 0. in_ready is low during the drain, so no new
// element is taken until the last result is loaded. Nonzero elements beyond
// MAX_ITEMS are dropped; overflow is raised on every result of that list.
// A stalled receiver holds the output register and the drain pauses.
// Reset (rst, synchronous) empties the chain and clears all counters.
module nonzero_descending_index_sort_core
  import ndis_pkg::*;
#(
  parameter int MAX_ITEMS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [ValueWidth-1:0] value,
  input  wire logic                         last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [ValueWidth-1:0]      sorted_value,
  output logic [IndexWidth-1:0]             source_index,
  output logic                              overflow,
  output logic                              end_of_list
);

  localparam int CountWidth = $clog2(MAX_ITEMS + 1);

  state_t                  state, state_next;
  logic [CountWidth-1:0]   kept_count, kept_count_next;
  logic [IndexWidth-1:0]   element_position, element_position_next;
  logic                    overflow_seen, overflow_seen_next;
  logic                    out_load, out_zero, out_eol;
  cell_ctrl_t              ctrl;
  entry_t                  new_entry;
  entry_t                  cells [MAX_ITEMS];
  logic                    keeps [MAX_ITEMS];
  logic                    not_full;

  assign not_full = kept_count < CountWidth'(MAX_ITEMS);

  assign new_entry.valid = 1'b1;
  assign new_entry.value = value;
  assign new_entry.pos   = element_position;

  always_comb begin
    state_next            = state;
    kept_count_next       = kept_count;
    element_position_next = element_position;
    overflow_seen_next    = overflow_seen;
    in_ready              = 1'b0;
    ctrl                  = '0;
    out_load              = 1'b0;
    out_zero              = 1'b0;
    out_eol               = 1'b0;
    case (state)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          element_position_next = element_position + 1'b1;
          if (value != '0) begin
            if (not_full) begin
              ctrl.insert     = 1'b1;
              kept_count_next = kept_count + 1'b1;
            end else begin
              overflow_seen_next = 1'b1;
            end
          end
          if (last) begin
            element_position_next = '0;
            state_next            = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (kept_count == '0) begin
            out_zero = 1'b1;
            out_eol  = 1'b1;
          end else begin
            ctrl.drain      = 1'b1;
            kept_count_next = kept_count - 1'b1;
            out_eol         = (kept_count == CountWidth'(1));
          end
          if (out_eol) begin
            overflow_seen_next = 1'b0;
            state_next         = ST_FILL;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_k;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_k = keeps[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end
    ndis_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .entry      (cells[i]),
      .keep       (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_FILL;
      kept_count       <= '0;
      element_position <= '0;
      overflow_seen    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      kept_count       <= kept_count_next;
      element_position <= element_position_next;
      overflow_seen    <= overflow_seen_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sorted_value <= out_zero ? '0 : cells[0].value;
      source_index <= out_zero ? '0 : cells[0].pos;
      overflow     <= overflow_seen;
      end_of_list  <= out_eol;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_nonzero_descending_index_sort_core.sv =====
`timescale 1ns / 1ps
module tb_nonzero_descending_index_sort_core;
  import ndis_pkg::*;

  localparam int MAX_KEPT = 32;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [ValueWidth-1:0] sorted_value;
    logic [IndexWidth-1:0]        source_index;
    logic                         overflow;
    logic                         end_of_list;
  } rank_t;

  typedef enum int {
    VEC_SHORT,
    VEC_SPARSE,
    VEC_ZERO,
    VEC_FULL,
    VEC_OVERFLOW,
    VEC_LONG
  } vec_kind_t;

  class ranked_list_board;
    logic signed [ValueWidth-1:0] chain_value [MAX_KEPT];
    logic [IndexWidth-1:0]        chain_pos [MAX_KEPT];
    int                           chain_len;
    logic [IndexWidth-1:0]        next_pos;
    logic                         dropped;
    rank_t                        expected_ranks[$];
    int                           mismatches;
    int                           ranks_seen;

    function new();
      chain_len = 0;
      next_pos = '0;
      dropped = 1'b0;
      mismatches = 0;
      ranks_seen = 0;
    endfunction

    function int pending();
      return expected_ranks.size();
    endfunction

    // Insertion chain: equal values keep arrival order.
    function void take_element(logic signed [ValueWidth-1:0] v, logic fin);
      int slot;
      int j;
      rank_t r;
      if (v != 0) begin
        if (chain_len < MAX_KEPT) begin
          slot = 0;
          while (slot < chain_len && chain_value[slot] >= v) slot++;
          for (j = chain_len; j > slot; j--) begin
            chain_value[j] = chain_value[j-1];
            chain_pos[j] = chain_pos[j-1];
          end
          chain_value[slot] = v;
          chain_pos[slot] = next_pos;
          chain_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      next_pos = next_pos + 1'b1;
      if (!fin) return;
      if (chain_len == 0) begin
        r.sorted_value = '0;
        r.source_index = '0;
        r.overflow = dropped;
        r.end_of_list = 1'b1;
        expected_ranks = {expected_ranks, r};
      end else begin
        for (j = 0; j < chain_len; j++) begin
          r.sorted_value = chain_value[j];
          r.source_index = chain_pos[j];
          r.overflow = dropped;
          r.end_of_list = (j == chain_len - 1);
          expected_ranks = {expected_ranks, r};
        end
      end
      chain_len = 0;
      next_pos = '0;
      dropped = 1'b0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH rank %0d: %s", ranks_seen, msg);
      mismatches++;
    endtask

    task check_rank(logic signed [ValueWidth-1:0] sv, logic [IndexWidth-1:0] si,
                    logic ov, logic eol);
      rank_t want;
      if (expected_ranks.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d index %0d", sv, si));
        ranks_seen++;
        return;
      end
      want = expected_ranks.pop_front();
      if (sv !== want.sorted_value)
        report_mismatch($sformatf("sorted_value %0d, want %0d", sv, want.sorted_value));
      if (si !== want.source_index)
        report_mismatch($sformatf("source_index %0d, want %0d", si, want.source_index));
      if (ov !== want.overflow)
        report_mismatch($sformatf("overflow %b, want %b", ov, want.overflow));
      if (eol !== want.end_of_list)
        report_mismatch($sformatf("end_of_list %b, want %b", eol, want.end_of_list));
      ranks_seen++;
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [ValueWidth-1:0] value = '0;
  logic                         last = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [ValueWidth-1:0] sorted_value;
  logic [IndexWidth-1:0]        source_index;
  logic                         overflow;
  logic                         end_of_list;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  ranked_list_board board = new();

  int          send_pcts [4] = '{0, 66, 0, 33};
  int          recv_pcts [4] = '{0, 0, 66, 33};
  vec_kind_t   anchor_kinds [4] = '{VEC_OVERFLOW, VEC_LONG, VEC_FULL, VEC_OVERFLOW};

  nonzero_descending_index_sort_core #(.MAX_ITEMS(MAX_KEPT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sorted_value(sorted_value),
    .source_index(source_index),
    .overflow(overflow),
    .end_of_list(end_of_list)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.take_element(value, last);
      if (out_valid && out_ready)
        board.check_rank(sorted_value, source_index, overflow, end_of_list);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nonzero_descending_index_sort_core verification failed");
      $finish;
    end
  end

  function automatic logic signed [ValueWidth-1:0] pick_value(int unsigned zero_pct);
    if ($urandom_range(99) < zero_pct) return '0;
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(8)) - 4;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return {($urandom_range(1) ? 16'hffff : 16'h0000), 16'($urandom)};
    endcase
  endfunction

  function automatic vec_kind_t pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 58) return VEC_SHORT;
    if (roll < 83) return VEC_SPARSE;
    if (roll < 90) return VEC_ZERO;
    if (roll < 94) return VEC_FULL;
    if (roll < 97) return VEC_OVERFLOW;
    return VEC_LONG;
  endfunction

  task automatic send_element(input logic signed [ValueWidth-1:0] v, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    value <= v;
    last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_values(input logic signed [ValueWidth-1:0] vals[$]);
    int k;
    for (k = 0; k < vals.size(); k++) send_element(vals[k], k == vals.size() - 1);
  endtask

  task automatic send_random_vector(input vec_kind_t kind);
    logic signed [ValueWidth-1:0] vals[$];
    logic signed [ValueWidth-1:0] v;
    int len;
    int nz;
    int target;
    case (kind)
      VEC_SHORT: begin
        len = $urandom_range(8, 1);
        repeat (len) vals = {vals, pick_value(25)};
      end
      VEC_SPARSE: begin
        len = $urandom_range(12, 1);
        repeat (len) vals = {vals, pick_value(70)};
      end
      VEC_ZERO: begin
        len = $urandom_range(4, 1);
        repeat (len) vals = {vals, 32'sd0};
      end
      VEC_FULL, VEC_OVERFLOW: begin
        target = (kind == VEC_FULL) ? MAX_KEPT : $urandom_range(MAX_KEPT + 13, MAX_KEPT + 1);
        nz = 0;
        while (nz < target) begin
          v = pick_value(10);
          vals = {vals, v};
          if (v != 0) nz++;
        end
      end
      default: begin
        // past 64 elements so the position counter wraps
        len = $urandom_range(90, 65);
        repeat (len) vals = {vals, pick_value(75)};
      end
    endcase
    send_values(vals);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic signed [ValueWidth-1:0] vals[$];
    int phase;
    int phase_end;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    vals = '{32'sh7fffffff};
    send_values(vals);
    vals = '{32'sh80000000};
    send_values(vals);
    vals = '{32'sh0};
    send_values(vals);
    vals = '{-32'sd1, 32'sd1, 32'sd0, 32'sd1, -32'sd1, 32'sh80000000, 32'sh7fffffff};
    send_values(vals);
    vals = '{32'sd5, 32'sd5, 32'sd5};
    send_values(vals);
    vals = '{32'sd0, 32'sd3};
    send_values(vals);
    vals = '{32'shaaaaaaaa, 32'sh55555555};
    send_values(vals);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      phase_end = items_sent + ITEMS_PER_PHASE;
      send_random_vector(anchor_kinds[phase]);
      while (items_sent < phase_end) send_random_vector(pick_kind());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
    if (board.mismatches == 0) begin
      $display("nonzero_descending_index_sort_core verification clean");
    end else begin
      $display("nonzero_descending_index_sort_core verification failed");
    end
    $finish;
  end

endmodule
